// File: hw/rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants for the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

    // fixed field widths
    localparam int CFG_W   = 20;
    localparam int AVG_W   = 7;
    localparam int SCALE_W = 16;
    localparam int DIST_W  = 19;
    localparam int SUM_W   = 25;
    localparam int IDX_W   = 3;
    localparam int S_DW    = 8;
    localparam int M_DW    = 24;

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // register indexes
    localparam logic [IDX_W-1:0] REG_GAP       = 3'd0;
    localparam logic [IDX_W-1:0] REG_TRIGGER   = 3'd1;
    localparam logic [IDX_W-1:0] REG_TIMEOUT   = 3'd2;
    localparam logic [IDX_W-1:0] REG_AVG_COUNT = 3'd3;
    localparam logic [IDX_W-1:0] REG_AVG_EN    = 3'd4;
    localparam logic [IDX_W-1:0] REG_SCALE     = 3'd5;
    localparam logic [IDX_W-1:0] REG_RANGE     = 3'd6;

    // register reset values
    localparam logic [CFG_W-1:0]   GAP_RST       = 20'd1000;
    localparam logic [CFG_W-1:0]   TRIGGER_RST   = 20'd10;
    localparam logic [CFG_W-1:0]   TIMEOUT_RST   = 20'd23000;
    localparam logic [AVG_W-1:0]   AVG_COUNT_RST = 7'd10;
    localparam logic               AVG_EN_RST    = 1'b1;
    localparam logic [SCALE_W-1:0] SCALE_RST     = 16'd2248;
    localparam logic [DIST_W-1:0]  RANGE_RST     = 19'd20;

    typedef struct packed {
        logic [CFG_W-1:0]   gap_ticks;
        logic [CFG_W-1:0]   trigger_ticks;
        logic [CFG_W-1:0]   timeout_ticks;
        logic [AVG_W-1:0]   average_count;
        logic               average_enable;
        logic [SCALE_W-1:0] speed_scale;
        logic [DIST_W-1:0]  obstacle_range;
    } cfg_t;

    // measurement phase, one-hot
    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_GAP   = 6'b000010,
        PH_TRIG  = 6'b000100,
        PH_WLOW  = 6'b001000,
        PH_WHIGH = 6'b010000,
        PH_MEAS  = 6'b100000
    } phase_t;

    // sequencer state, one-hot
    typedef enum logic [3:0] {
        ST_RUN = 4'b0001,
        ST_DIV = 4'b0010,
        ST_MUL = 4'b0100,
        ST_FIN = 4'b1000
    } ctl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic tick_clr;
        logic tick_inc;
        logic meas_start;
        logic arm;
        logic to_inc;
        logic pulse_set;
        logic pulse_inc;
        logic fin;
        logic fin_echo;
        logic div_load;
        logic div_step;
        logic mul_go;
        logic out_tick;
        logic out_trig;
        logic out_busy;
        logic out_final;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic gap_zero;
        logic gap_hit;
        logic trig_hit;
        logic to_hit;
        logic last_sample;
        logic div_last;
        logic out_free;
    } dp_stat_t;

endpackage

// File: hw/rtl/uer_cfg.sv
// ----------------------------------------------------------------------------
// uer_cfg
// Configuration register file with a write-only valid/ready port.
// ----------------------------------------------------------------------------
module uer_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [uer_pkg::IDX_W-1:0]    cfg_index,
    input  logic [uer_pkg::CFG_W-1:0]    cfg_data,
    output uer_pkg::cfg_t                cfg
);

    uer_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap_ticks      <= uer_pkg::GAP_RST;
            cfg_reg.trigger_ticks  <= uer_pkg::TRIGGER_RST;
            cfg_reg.timeout_ticks  <= uer_pkg::TIMEOUT_RST;
            cfg_reg.average_count  <= uer_pkg::AVG_COUNT_RST;
            cfg_reg.average_enable <= uer_pkg::AVG_EN_RST;
            cfg_reg.speed_scale    <= uer_pkg::SCALE_RST;
            cfg_reg.obstacle_range <= uer_pkg::RANGE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                uer_pkg::REG_GAP:       cfg_reg.gap_ticks      <= cfg_data;
                uer_pkg::REG_TRIGGER:   cfg_reg.trigger_ticks  <= cfg_data;
                uer_pkg::REG_TIMEOUT:   cfg_reg.timeout_ticks  <= cfg_data;
                uer_pkg::REG_AVG_COUNT:
                    cfg_reg.average_count  <= cfg_data[uer_pkg::AVG_W-1:0];
                uer_pkg::REG_AVG_EN:    cfg_reg.average_enable <= cfg_data[0];
                uer_pkg::REG_SCALE:
                    cfg_reg.speed_scale    <= cfg_data[uer_pkg::SCALE_W-1:0];
                uer_pkg::REG_RANGE:
                    cfg_reg.obstacle_range <= cfg_data[uer_pkg::DIST_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// File: hw/rtl/uer_ctrl.sv
// ----------------------------------------------------------------------------
// uer_ctrl
// Measurement phase sequencer and result sequencer.
// ----------------------------------------------------------------------------
module uer_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                tick_cmd,
    input  logic                tick_echo,
    input  uer_pkg::dp_stat_t   stat,
    output uer_pkg::dp_cmd_t    cmd
);

    uer_pkg::phase_t     phase_reg, phase_next;
    uer_pkg::ctl_state_t st_reg, st_next;
    logic                acc;
    logic                ended;
    logic                fin_last;

    assign s_tready = (st_reg == uer_pkg::ST_RUN) && stat.out_free;
    assign acc      = s_tvalid && s_tready;

    always_comb
    begin
        cmd        = '0;
        phase_next = phase_reg;
        st_next    = st_reg;
        ended      = 1'b0;
        fin_last   = 1'b0;
        case (st_reg)
            uer_pkg::ST_RUN:
            begin
                if (acc)
                begin
                    case (phase_reg)
                        uer_pkg::PH_IDLE:
                        begin
                            if (tick_cmd)
                            begin
                                cmd.meas_start = 1'b1;
                                cmd.tick_clr   = 1'b1;
                                phase_next     = stat.gap_zero ? uer_pkg::PH_TRIG
                                                               : uer_pkg::PH_GAP;
                            end
                        end
                        uer_pkg::PH_GAP:
                        begin
                            cmd.tick_inc = 1'b1;
                            if (stat.gap_hit)
                            begin
                                cmd.tick_clr = 1'b1;
                                phase_next   = uer_pkg::PH_TRIG;
                            end
                        end
                        uer_pkg::PH_TRIG:
                        begin
                            cmd.tick_inc = 1'b1;
                            if (stat.trig_hit)
                            begin
                                cmd.tick_clr = 1'b1;
                                cmd.arm      = 1'b1;
                                phase_next   = uer_pkg::PH_WLOW;
                            end
                        end
                        uer_pkg::PH_WLOW, uer_pkg::PH_WHIGH, uer_pkg::PH_MEAS:
                        begin
                            cmd.to_inc = 1'b1;
                            if (phase_reg == uer_pkg::PH_WLOW)
                            begin
                                if (!tick_echo)
                                    phase_next = uer_pkg::PH_WHIGH;
                            end
                            else if (phase_reg == uer_pkg::PH_WHIGH)
                            begin
                                if (tick_echo)
                                begin
                                    cmd.pulse_set = 1'b1;
                                    phase_next    = uer_pkg::PH_MEAS;
                                end
                            end
                            else
                            begin
                                if (tick_echo)
                                    cmd.pulse_inc = 1'b1;
                                else
                                begin
                                    // falling edge wins over timeout
                                    cmd.fin      = 1'b1;
                                    cmd.fin_echo = 1'b1;
                                    ended        = 1'b1;
                                end
                            end
                            if (!ended && stat.to_hit)
                                cmd.fin = 1'b1;
                            if (cmd.fin)
                            begin
                                if (stat.last_sample)
                                begin
                                    fin_last     = 1'b1;
                                    cmd.div_load = 1'b1;
                                    phase_next   = uer_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    cmd.tick_clr = 1'b1;
                                    phase_next   = stat.gap_zero ? uer_pkg::PH_TRIG
                                                                 : uer_pkg::PH_GAP;
                                end
                            end
                        end
                        default:
                            phase_next = uer_pkg::PH_IDLE;
                    endcase
                    if (fin_last)
                        st_next = uer_pkg::ST_DIV;
                    else
                    begin
                        cmd.out_tick = 1'b1;
                        cmd.out_trig = (phase_next == uer_pkg::PH_TRIG);
                        cmd.out_busy = (phase_next != uer_pkg::PH_IDLE);
                    end
                end
            end
            uer_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    st_next = uer_pkg::ST_MUL;
            end
            uer_pkg::ST_MUL:
            begin
                cmd.mul_go = 1'b1;
                st_next    = uer_pkg::ST_FIN;
            end
            uer_pkg::ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_final = 1'b1;
                    st_next       = uer_pkg::ST_RUN;
                end
            end
            default:
                st_next = uer_pkg::ST_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= uer_pkg::PH_IDLE;
            st_reg    <= uer_pkg::ST_RUN;
        end
        else
        begin
            phase_reg <= phase_next;
            st_reg    <= st_next;
        end
    end

    // phase only moves while ticks are taken
    a_idle_off_run: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != uer_pkg::ST_RUN) |-> (phase_reg == uer_pkg::PH_IDLE))
        else $error("phase not idle outside run state");

    a_final_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && fin_last) |=> (st_reg == uer_pkg::ST_DIV))
        else $error("final beat did not start division");

    a_fin_to_run: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == uer_pkg::ST_FIN && stat.out_free) |=> (st_reg == uer_pkg::ST_RUN))
        else $error("result beat not issued");

endmodule

// File: hw/rtl/uer_dp.sv
// ----------------------------------------------------------------------------
// uer_dp
// Counters, echo sum, serial divider, scale multiplier and result register.
// ----------------------------------------------------------------------------
module uer_dp #(
    parameter int COUNTER_BITS    = 20,
    parameter int MAX_SAMPLES     = 64,
    parameter int SCALE_FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  uer_pkg::cfg_t              cfg,
    input  uer_pkg::dp_cmd_t           cmd,
    output uer_pkg::dp_stat_t          stat,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [uer_pkg::M_DW-1:0]   m_tdata
);

    localparam int CW    = COUNTER_BITS;
    localparam int LW    = (uer_pkg::CFG_W > CW) ? uer_pkg::CFG_W : CW;
    localparam int SMP_W = CW - 1;
    localparam int AW    = ((uer_pkg::SUM_W > SMP_W) ? uer_pkg::SUM_W : SMP_W) + 1;
    localparam int SD_W  = $clog2(MAX_SAMPLES + 1);
    localparam int TW    = (SD_W > uer_pkg::AVG_W) ? SD_W : uer_pkg::AVG_W;
    localparam int DC_W  = $clog2(uer_pkg::SUM_W + 1);
    localparam int PW    = uer_pkg::SUM_W + uer_pkg::SCALE_W;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    function automatic logic [CW-1:0] lim_f(input logic [uer_pkg::CFG_W-1:0] v);
        logic [LW-1:0] ve;
        ve = LW'(v);
        if (v == '0)
            return CW'(1);
        else if (ve > LW'(CNT_MAX))
            return CNT_MAX;
        else
            return ve[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] inc_sat_f(input logic [CW-1:0] v);
        return (v == CNT_MAX) ? v : v + CW'(1);
    endfunction

    logic [CW-1:0]              tick_reg, to_reg, pulse_reg;
    logic [SD_W-1:0]            samples_reg;
    logic [uer_pkg::SUM_W-1:0]  sum_reg;
    logic [uer_pkg::SUM_W-1:0]  quo_reg;
    logic [SD_W-1:0]            rem_reg;
    logic [DC_W-1:0]            dcnt_reg;
    logic [PW-1:0]              prod_reg;
    logic [uer_pkg::DIST_W-1:0] last_dist_reg;
    logic                       last_obs_reg;
    logic                       ov_reg;
    logic                       o_trig_reg, o_busy_reg, o_done_reg, o_obs_reg;
    logic [uer_pkg::DIST_W-1:0] o_dist_reg;

    logic [CW-1:0]              tick_inc, to_inc;
    logic [AW-1:0]              sample_ext, sum_add;
    logic [uer_pkg::SUM_W-1:0]  sum_next;
    logic [SD_W-1:0]            samples_inc;
    logic [TW-1:0]              ac_ext, tgt_wide;
    logic [SD_W-1:0]            target;
    logic [SD_W:0]              rem_sh, rem_diff;
    logic                       rem_ge;
    logic [PW-1:0]              prod_sh;
    logic [uer_pkg::DIST_W-1:0] dist_new;
    logic                       obs_new;

    assign tick_inc = inc_sat_f(tick_reg);
    assign to_inc   = inc_sat_f(to_reg);

    // sample count target
    always_comb
    begin
        ac_ext = TW'(cfg.average_count);
        if (!cfg.average_enable || ac_ext == '0)
            tgt_wide = TW'(1);
        else if (ac_ext > TW'(MAX_SAMPLES))
            tgt_wide = TW'(MAX_SAMPLES);
        else
            tgt_wide = ac_ext;
    end
    assign target      = tgt_wide[SD_W-1:0];
    assign samples_inc = samples_reg + SD_W'(1);

    // saturating sum of halved widths
    assign sample_ext = cmd.fin_echo ? AW'(pulse_reg[CW-1:1]) : '0;
    assign sum_add    = AW'(sum_reg) + sample_ext;
    assign sum_next   = (sum_add > AW'(uer_pkg::SUM_MAX)) ? uer_pkg::SUM_MAX
                                                          : sum_add[uer_pkg::SUM_W-1:0];

    assign stat.gap_zero    = (cfg.gap_ticks == '0);
    assign stat.gap_hit     = (tick_inc >= lim_f(cfg.gap_ticks));
    assign stat.trig_hit    = (tick_inc >= lim_f(cfg.trigger_ticks));
    assign stat.to_hit      = (to_inc >= lim_f(cfg.timeout_ticks));
    assign stat.last_sample = (samples_inc >= target);
    assign stat.div_last    = (dcnt_reg == DC_W'(1));
    assign stat.out_free    = !ov_reg || m_tready;

    // restoring divider step, one quotient bit per cycle
    assign rem_sh   = {rem_reg, quo_reg[uer_pkg::SUM_W-1]};
    assign rem_ge   = (rem_sh >= (SD_W+1)'(samples_reg));
    assign rem_diff = rem_sh - (SD_W+1)'(samples_reg);

    // scale and saturate
    assign prod_sh  = prod_reg >> SCALE_FRAC_BITS;
    assign dist_new = (prod_sh > PW'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX
                                                         : prod_sh[uer_pkg::DIST_W-1:0];
    assign obs_new  = (dist_new <= cfg.obstacle_range);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            to_reg        <= '0;
            pulse_reg     <= '0;
            samples_reg   <= '0;
            sum_reg       <= '0;
            dcnt_reg      <= '0;
            last_dist_reg <= '0;
            last_obs_reg  <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.tick_clr)
                tick_reg <= '0;
            else if (cmd.tick_inc)
                tick_reg <= tick_inc;

            if (cmd.arm)
                to_reg <= '0;
            else if (cmd.to_inc)
                to_reg <= to_inc;

            if (cmd.arm)
                pulse_reg <= '0;
            else if (cmd.pulse_set)
                pulse_reg <= CW'(1);
            else if (cmd.pulse_inc)
                pulse_reg <= inc_sat_f(pulse_reg);

            if (cmd.meas_start)
            begin
                samples_reg <= '0;
                sum_reg     <= '0;
            end
            else if (cmd.fin)
            begin
                samples_reg <= samples_inc;
                sum_reg     <= sum_next;
            end

            if (cmd.div_load)
                dcnt_reg <= DC_W'(uer_pkg::SUM_W);
            else if (cmd.div_step)
                dcnt_reg <= dcnt_reg - DC_W'(1);

            if (cmd.out_final)
            begin
                last_dist_reg <= dist_new;
                last_obs_reg  <= obs_new;
            end

            if (cmd.out_tick || cmd.out_final)
                ov_reg <= 1'b1;
            else if (m_tready)
                ov_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            quo_reg <= sum_next;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[uer_pkg::SUM_W-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_diff[SD_W-1:0] : rem_sh[SD_W-1:0];
        end

        if (cmd.mul_go)
            prod_reg <= PW'(quo_reg) * PW'(cfg.speed_scale);

        if (cmd.out_tick)
        begin
            o_trig_reg <= cmd.out_trig;
            o_busy_reg <= cmd.out_busy;
            o_done_reg <= 1'b0;
            o_dist_reg <= last_dist_reg;
            o_obs_reg  <= last_obs_reg;
        end
        else if (cmd.out_final)
        begin
            o_trig_reg <= 1'b0;
            o_busy_reg <= 1'b0;
            o_done_reg <= 1'b1;
            o_dist_reg <= dist_new;
            o_obs_reg  <= obs_new;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {1'b0, o_obs_reg, o_dist_reg, o_done_reg, o_busy_reg, o_trig_reg};

endmodule

// File: hw/rtl/ultrasonic_echo_ranger_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit
// Time-of-flight ranger driven by one input beat per echo sample tick.
// ----------------------------------------------------------------------------
// Each input beat is one tick: it carries the sampled echo level and a start
// flag, and yields exactly one output beat with the trigger drive level, busy,
// done, the latest distance and the obstacle flag as they stand after that
// tick. A start while idle runs gap_ticks ticks of trigger low, trigger_ticks
// ticks of trigger high, then waits for echo low, echo high and times the high
// width; timeout_ticks bounds the wait plus the width, after which the sample
// is zero. Samples are halved and summed, and in averaging mode divided by the
// sample count before the Q0.16 speed scale is applied. On ordinary ticks a beat
// can enter every cycle while the output is drained. The tick that completes a
// measurement instead runs a radix-2 serial divider over the 25-bit echo sum,
// then the scale multiply, then forms the result beat; no input is taken
// meanwhile. Configuration is written through cfg_*; the user must write it
// only while no measurement is running, as the block does not enforce this.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_unit #(
    parameter int COUNTER_BITS    = 20,
    parameter int MAX_SAMPLES     = 64,
    parameter int SCALE_FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // input beat: [0] cmd, [1] echo_level, [7:2] zero
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [uer_pkg::S_DW-1:0]   s_tdata,
    // output beat: [0] trigger_level, [1] busy_res, [2] done_res,
    // [21:3] distance, [22] obstacle, [23] zero
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [uer_pkg::M_DW-1:0]   m_tdata,
    // register write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [uer_pkg::IDX_W-1:0]  cfg_index,
    input  logic [uer_pkg::CFG_W-1:0]  cfg_data
);

    uer_pkg::cfg_t      cfg;
    uer_pkg::dp_cmd_t   cmd;
    uer_pkg::dp_stat_t  stat;

    // register file
    uer_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // phase sequencing and result sequencing
    uer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .tick_cmd  (s_tdata[0]),
        .tick_echo (s_tdata[1]),
        .stat      (stat),
        .cmd       (cmd)
    );

    // counters, sum, divider, multiplier and output register
    uer_dp #(
        .COUNTER_BITS    (COUNTER_BITS),
        .MAX_SAMPLES     (MAX_SAMPLES),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
